// ===== rtl/core/ibhq_pkg.sv =====
// Package for the indexed binary heap queue: payload structs, operation and
// status codes, controller/datapath command and status types.
// No dependencies.
package ibhq_pkg;

   localparam int KEY_BITS    = 32;
   localparam int TAG_BITS    = 16;
   localparam int SLOT_BITS   = 8;
   localparam int MAX_ENTRIES = 255;
   localparam int RAM_DEPTH   = 256;

   localparam logic [2:0] MODE_ADD    = 3'd0;
   localparam logic [2:0] MODE_POP    = 3'd1;
   localparam logic [2:0] MODE_PEEK   = 3'd2;
   localparam logic [2:0] MODE_REMOVE = 3'd3;
   localparam logic [2:0] MODE_REKEY  = 3'd4;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_FULL   = 2'd1;
   localparam logic [1:0] STATUS_EMPTY  = 2'd2;
   localparam logic [1:0] STATUS_BADPOS = 2'd3;

   localparam logic CSR_ORDER    = 1'b0;
   localparam logic CSR_CAPACITY = 1'b1;

   typedef struct packed {
      logic [2:0]          mode;
      logic [KEY_BITS-1:0] key;
      logic [TAG_BITS-1:0] tag;
      logic [7:0]          position;
   } req_type;

   typedef struct packed {
      logic [TAG_BITS-1:0] entry_tag;
      logic [KEY_BITS-1:0] entry_key;
      logic [7:0]          new_position;
      logic [1:0]          status;
      logic [7:0]          entry_count;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic [KEY_BITS-1:0] key;
      logic [TAG_BITS-1:0] tag;
   } entry_type;

   typedef enum logic [2:0] {
      RD_ONE, RD_POS, RD_LAST, RD_PARENT, RD_LEFT, RD_RIGHT
   } rd_sel_type;

   typedef enum logic [3:0] {
      CAP_NONE, CAP_REQ, CAP_RET, CAP_MOV, CAP_REKEY, CAP_UP, CAP_LEFT,
      CAP_LEFT_ONLY, CAP_CHOOSE
   } cap_type;

   typedef enum logic [2:0] {
      POS_HOLD, POS_ADD, POS_ONE, POS_REQ, POS_NEXT
   } pos_op_type;

   typedef enum logic [1:0] {
      CNT_HOLD, CNT_INC, CNT_DEC
   } cnt_op_type;

   typedef enum logic [1:0] {
      WR_NONE, WR_OTH, WR_MOV
   } wr_sel_type;

   typedef enum logic [3:0] {
      EMIT_NONE, EMIT_MOV, EMIT_OTH, EMIT_RET, EMIT_CLOSE_MOV, EMIT_CLOSE_RET,
      EMIT_CLOSE_PEEK, EMIT_CLOSE_ERR, EMIT_CLOSE_NOP
   } emit_type;

   typedef struct packed {
      logic       load_req;
      logic       rd_en;
      rd_sel_type rd_sel;
      cap_type    cap;
      pos_op_type pos_op;
      cnt_op_type cnt_op;
      wr_sel_type wr_sel;
      emit_type   emit;
   } cmd_type;

   typedef struct packed {
      logic [2:0] mode;
      logic       err;
      logic       out_free;
      logic       at_root;
      logic       has_left;
      logic       has_right;
      logic       up_stays;
      logic       dn_stays;
      logic       was_last;
   } stat_type;

   typedef enum logic [4:0] {
      S_IDLE, S_DECODE, S_TAKE1, S_TAKE2, S_RK, S_PEEK, S_RET_N, S_MOV_N,
      S_UP_CHK, S_UP_CMP, S_DN_CHK, S_DN_L, S_DN_R, S_DN_CMP, S_SWAP,
      S_EMIT_A, S_EMIT_B, S_FIN, S_CLOSE
   } state_type;

   // true when key a may stay above key b
   function automatic logic stays_above(input logic order_max,
                                        input logic [KEY_BITS-1:0] a,
                                        input logic [KEY_BITS-1:0] b);
      return order_max ? (a >= b) : (a <= b);
   endfunction

endpackage

// ===== rtl/core/ibhq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ibhq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/ibhq_dpath.sv =====
// Datapath: heap slot RAM, moving-entry and walk registers, size and config
// registers, result register. Depends on ibhq_pkg and ibhq_ram.
module ibhq_dpath (
   input  logic              clock,
   input  logic              reset,
   input  ibhq_pkg::req_type req_data,
   input  logic              csr_valid,
   input  logic              csr_index,
   input  logic [7:0]        csr_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ibhq_pkg::rsp_type rsp_data,
   input  ibhq_pkg::cmd_type cmd,
   output ibhq_pkg::stat_type stat
);
   import ibhq_pkg::*;

   req_type   req_ff;
   entry_type mov_ff, oth_ff, ret_ff, lft_ff;
   logic [7:0] c_ff, c_in, prev_ff, nxt_ff, cnt_ff, cnt_in, cap_ff;
   logic       order_ff;
   rsp_type   rsp_ff, rsp_in;
   logic      rsp_valid_ff;
   entry_type rd_data;
   logic [7:0] rd_addr;
   logic [8:0] left_idx, right_idx;
   logic       choose_left;
   logic [1:0] err_code;
   logic       is_add, is_pop, is_peek, is_rem, is_rekey;
   logic       full, empty, badpos;

   assign left_idx  = {c_ff, 1'b0};
   assign right_idx = {c_ff, 1'b1};
   assign choose_left = stays_above(order_ff, lft_ff.key, rd_data.key);

   always_comb begin
      unique case (cmd.rd_sel)
         RD_ONE:    rd_addr = 8'd1;
         RD_POS:    rd_addr = req_ff.position;
         RD_LAST:   rd_addr = cnt_ff;
         RD_PARENT: rd_addr = {1'b0, c_ff[7:1]};
         RD_LEFT:   rd_addr = left_idx[7:0];
         RD_RIGHT:  rd_addr = right_idx[7:0];
         default:   rd_addr = 8'd1;
      endcase
   end

   ibhq_ram #(.WIDTH($bits(entry_type)), .DEPTH(RAM_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_sel != WR_NONE),
      .wr_addr (c_ff),
      .wr_data ((cmd.wr_sel == WR_MOV) ? mov_ff : oth_ff),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // entry registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      unique case (cmd.cap)
         CAP_REQ:   mov_ff <= '{key: req_ff.key, tag: req_ff.tag};
         CAP_RET:   ret_ff <= rd_data;
         CAP_MOV:   mov_ff <= rd_data;
         CAP_REKEY: mov_ff <= '{key: req_ff.key, tag: rd_data.tag};
         CAP_UP: begin
            oth_ff <= rd_data;
            nxt_ff <= {1'b0, c_ff[7:1]};
         end
         CAP_LEFT:  lft_ff <= rd_data;
         CAP_LEFT_ONLY: begin
            oth_ff <= rd_data;
            nxt_ff <= left_idx[7:0];
         end
         CAP_CHOOSE: begin
            oth_ff <= choose_left ? lft_ff : rd_data;
            nxt_ff <= choose_left ? left_idx[7:0] : right_idx[7:0];
         end
         default: ;
      endcase
      if (cmd.pos_op == POS_NEXT) begin
         prev_ff <= c_ff;
      end
      c_ff <= c_in;
   end

   always_comb begin
      unique case (cmd.pos_op)
         POS_ADD:  c_in = cnt_ff + 8'd1;
         POS_ONE:  c_in = 8'd1;
         POS_REQ:  c_in = req_ff.position;
         POS_NEXT: c_in = nxt_ff;
         default:  c_in = c_ff;
      endcase
      unique case (cmd.cnt_op)
         CNT_INC: cnt_in = cnt_ff + 8'd1;
         CNT_DEC: cnt_in = cnt_ff - 8'd1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         order_ff <= 1'b0;
         cap_ff   <= 8'd255;
      end else begin
         cnt_ff <= cnt_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_ORDER:    order_ff <= csr_data[0];
               CSR_CAPACITY: cap_ff   <= csr_data;
               default: ;
            endcase
         end
      end
   end

   assign is_add   = (req_ff.mode == MODE_ADD);
   assign is_pop   = (req_ff.mode == MODE_POP);
   assign is_peek  = (req_ff.mode == MODE_PEEK);
   assign is_rem   = (req_ff.mode == MODE_REMOVE);
   assign is_rekey = (req_ff.mode == MODE_REKEY);
   assign full   = (cnt_ff >= cap_ff) || (32'(cnt_ff) >= MAX_ENTRIES);
   assign empty  = (cnt_ff == 8'd0);
   assign badpos = (req_ff.position == 8'd0) || (req_ff.position > cnt_ff);

   always_comb begin
      priority if (is_add) begin
         err_code = STATUS_FULL;
      end else if (empty) begin
         err_code = STATUS_EMPTY;
      end else begin
         err_code = STATUS_BADPOS;
      end
   end

   assign stat.mode      = req_ff.mode;
   assign stat.err       = (is_add && full)
                         || ((is_pop || is_peek || is_rem || is_rekey) && empty)
                         || ((is_rem || is_rekey) && badpos);
   assign stat.out_free  = !rsp_valid_ff || !rsp_stall;
   assign stat.at_root   = (c_ff <= 8'd1);
   assign stat.has_left  = (left_idx <= {1'b0, cnt_ff});
   assign stat.has_right = (right_idx <= {1'b0, cnt_ff});
   assign stat.up_stays  = stays_above(order_ff, rd_data.key, mov_ff.key);
   assign stat.dn_stays  = stays_above(order_ff, mov_ff.key, oth_ff.key);
   assign stat.was_last  = (req_ff.position > cnt_ff);

   // result register
   always_comb begin
      rsp_in = '0;
      unique case (cmd.emit)
         EMIT_MOV: begin
            rsp_in.entry_tag    = mov_ff.tag;
            rsp_in.entry_key    = mov_ff.key;
            rsp_in.new_position = c_ff;
         end
         EMIT_OTH: begin
            rsp_in.entry_tag    = oth_ff.tag;
            rsp_in.entry_key    = oth_ff.key;
            rsp_in.new_position = prev_ff;
         end
         EMIT_RET: begin
            rsp_in.entry_tag = ret_ff.tag;
            rsp_in.entry_key = ret_ff.key;
         end
         EMIT_CLOSE_MOV: begin
            rsp_in.entry_tag    = mov_ff.tag;
            rsp_in.entry_key    = mov_ff.key;
            rsp_in.new_position = c_ff;
            rsp_in.entry_count  = cnt_ff;
            rsp_in.last         = 1'b1;
         end
         EMIT_CLOSE_RET: begin
            rsp_in.entry_tag   = ret_ff.tag;
            rsp_in.entry_key   = ret_ff.key;
            rsp_in.entry_count = cnt_ff;
            rsp_in.last        = 1'b1;
         end
         EMIT_CLOSE_PEEK: begin
            rsp_in.entry_tag    = ret_ff.tag;
            rsp_in.entry_key    = ret_ff.key;
            rsp_in.new_position = 8'd1;
            rsp_in.entry_count  = cnt_ff;
            rsp_in.last         = 1'b1;
         end
         EMIT_CLOSE_ERR: begin
            rsp_in.status      = err_code;
            rsp_in.entry_count = cnt_ff;
            rsp_in.last        = 1'b1;
         end
         EMIT_CLOSE_NOP: begin
            rsp_in.status      = STATUS_OK;
            rsp_in.entry_count = cnt_ff;
            rsp_in.last        = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit != EMIT_NONE) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit != EMIT_NONE) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/core/ibhq_ctrl.sv =====
// Controller: sequences decode, slot reads, sift-up/sift-down walks, swaps
// and result beats. Depends on ibhq_pkg.
module ibhq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  ibhq_pkg::stat_type stat,
   output ibhq_pkg::cmd_type  cmd
);
   import ibhq_pkg::*;

   state_type state_ff, state_in;
   logic      up_ff, up_in, err_ff, err_in;
   logic      is_pop, is_rem;

   assign is_pop = (stat.mode == MODE_POP);
   assign is_rem = (stat.mode == MODE_REMOVE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         up_ff    <= 1'b0;
         err_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         up_ff    <= up_in;
         err_ff   <= err_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      up_in    = up_ff;
      err_in   = err_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            err_in = stat.err;
            priority if (stat.err) begin
               state_in = S_CLOSE;
            end else if (stat.mode == MODE_ADD) begin
               cmd.cap    = CAP_REQ;
               cmd.pos_op = POS_ADD;
               cmd.cnt_op = CNT_INC;
               state_in   = S_MOV_N;
            end else if (stat.mode == MODE_POP || stat.mode == MODE_REMOVE) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = is_pop ? RD_ONE : RD_POS;
               state_in   = S_TAKE1;
            end else if (stat.mode == MODE_PEEK) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_ONE;
               state_in   = S_PEEK;
            end else if (stat.mode == MODE_REKEY) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_POS;
               state_in   = S_RK;
            end else begin
               state_in = S_CLOSE;
            end
         end
         S_TAKE1: begin
            // keep the leaving entry, fetch the last slot, shrink
            cmd.cap    = CAP_RET;
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_LAST;
            cmd.cnt_op = CNT_DEC;
            state_in   = S_TAKE2;
         end
         S_TAKE2: begin
            cmd.cap    = CAP_MOV;
            cmd.pos_op = is_pop ? POS_ONE : POS_REQ;
            state_in   = is_pop ? S_MOV_N : S_RET_N;
         end
         S_RK: begin
            cmd.cap    = CAP_REKEY;
            cmd.pos_op = POS_REQ;
            state_in   = S_UP_CHK;
         end
         S_PEEK: begin
            cmd.cap  = CAP_RET;
            state_in = S_CLOSE;
         end
         S_RET_N: begin
            if (stat.out_free) begin
               cmd.emit = EMIT_RET;
               priority if (is_pop || stat.was_last) begin
                  state_in = S_CLOSE;
               end else begin
                  state_in = S_MOV_N;
               end
            end
         end
         S_MOV_N: begin
            if (stat.out_free) begin
               cmd.emit = EMIT_MOV;
               state_in = is_pop ? S_DN_CHK : S_UP_CHK;
            end
         end
         S_UP_CHK: begin
            if (stat.at_root) begin
               state_in = S_DN_CHK;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_PARENT;
               state_in   = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            cmd.cap = CAP_UP;
            if (stat.up_stays) begin
               state_in = S_DN_CHK;
            end else begin
               up_in    = 1'b1;
               state_in = S_SWAP;
            end
         end
         S_DN_CHK: begin
            if (!stat.has_left) begin
               state_in = S_FIN;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_LEFT;
               state_in   = S_DN_L;
            end
         end
         S_DN_L: begin
            if (stat.has_right) begin
               cmd.cap    = CAP_LEFT;
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_RIGHT;
               state_in   = S_DN_R;
            end else begin
               cmd.cap  = CAP_LEFT_ONLY;
               state_in = S_DN_CMP;
            end
         end
         S_DN_R: begin
            cmd.cap  = CAP_CHOOSE;
            state_in = S_DN_CMP;
         end
         S_DN_CMP: begin
            if (stat.dn_stays) begin
               state_in = S_FIN;
            end else begin
               up_in    = 1'b0;
               state_in = S_SWAP;
            end
         end
         S_SWAP: begin
            // drop the other entry into the current slot, advance
            cmd.wr_sel = WR_OTH;
            cmd.pos_op = POS_NEXT;
            state_in   = S_EMIT_A;
         end
         S_EMIT_A: begin
            if (stat.out_free) begin
               cmd.emit = EMIT_MOV;
               state_in = S_EMIT_B;
            end
         end
         S_EMIT_B: begin
            if (stat.out_free) begin
               cmd.emit = EMIT_OTH;
               state_in = up_ff ? S_UP_CHK : S_DN_CHK;
            end
         end
         S_FIN: begin
            cmd.wr_sel = WR_MOV;
            state_in   = is_pop ? S_RET_N : S_CLOSE;
         end
         S_CLOSE: begin
            if (stat.out_free) begin
               priority if (err_ff) begin
                  cmd.emit = EMIT_CLOSE_ERR;
               end else if (stat.mode == MODE_ADD || stat.mode == MODE_REKEY) begin
                  cmd.emit = EMIT_CLOSE_MOV;
               end else if (is_pop || is_rem) begin
                  cmd.emit = EMIT_CLOSE_RET;
               end else if (stat.mode == MODE_PEEK) begin
                  cmd.emit = EMIT_CLOSE_PEEK;
               end else begin
                  cmd.emit = EMIT_CLOSE_NOP;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

// ===== rtl/core/indexed_binary_heap_queue.sv =====
// Indexed binary heap priority queue, top level: controller plus datapath.
// Depends on ibhq_pkg, ibhq_ctrl, ibhq_dpath, ibhq_ram.
//
// One operation (add, pop, peek, remove, rekey) is taken at a time and
// answered by a run of result beats: a position notice for every entry
// that moves, for pop and remove a beat with the removed entry, then one
// closing beat with last set. Entries live in a single-port-read slot RAM,
// so each heap level visited costs one read per slot: a sift-up level reads
// the parent, compares, swaps and sends two notice beats; a sift-down level
// reads the children, picks the one that stays above, compares, swaps and
// sends two notice beats. The request side stays stalled until the closing
// beat is issued, so result-side stalls lengthen an operation. A new item
// is taken while its predecessor's closing beat still waits in the output
// register.
// Configuration is written through the csr port, which is always ready;
// index 0 sets the ordering (bit 0 high for max), index 1 the capacity.
module indexed_binary_heap_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ibhq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ibhq_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [7:0]        csr_data
);
   import ibhq_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   ibhq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   ibhq_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

// ===== sim/ibhq_checker.sv =====
// Checker for the indexed binary heap queue: watches the request, result and
// csr channels, keeps its own heap copy and compares every result beat.
// Depends on ibhq_pkg.
module ibhq_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  ibhq_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  ibhq_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic              csr_index,
   input  logic [7:0]        csr_data,
   output int                fail_count,
   output int                pending
);
   import ibhq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   entry_type heap_slots [0:RAM_DEPTH-1];
   int        fill_level;
   logic      max_order;
   int        heap_limit;
   rsp_type   expected_beats [$];

   assign pending = expected_beats.size();

   function automatic bit keeps_above(int a, int b);
      if (max_order)
         return heap_slots[a].key >= heap_slots[b].key;
      return heap_slots[a].key <= heap_slots[b].key;
   endfunction

   function automatic void push_beat(entry_type e, int slot, logic [1:0] st,
                                     int cnt, logic fin);
      rsp_type r;
      r.entry_tag    = e.tag;
      r.entry_key    = e.key;
      r.new_position = slot[7:0];
      r.status       = st;
      r.entry_count  = cnt[7:0];
      r.last         = fin;
      expected_beats.push_back(r);
   endfunction

   function automatic void post_slot(int slot);
      push_beat(heap_slots[slot], slot, STATUS_OK, 0, 1'b0);
   endfunction

   function automatic void swap_slots(int a, int b);
      entry_type t;
      t = heap_slots[a];
      heap_slots[a] = heap_slots[b];
      heap_slots[b] = t;
      post_slot(a);
      post_slot(b);
   endfunction

   function automatic int sink(int c);
      int l, r, n;
      while (c <= fill_level / 2) begin
         l = 2 * c;
         r = l + 1;
         n = (r > fill_level || keeps_above(l, r)) ? l : r;
         if (keeps_above(c, n))
            break;
         swap_slots(n, c);
         c = n;
      end
      return c;
   endfunction

   function automatic int rise(int c);
      while (c > 1) begin
         if (keeps_above(c / 2, c))
            break;
         swap_slots(c / 2, c);
         c = c / 2;
      end
      return c;
   endfunction

   function automatic void apply_op(req_type q);
      entry_type zero, got;
      int c, p;
      zero = '0;
      p = int'(q.position);
      case (q.mode)
         MODE_ADD: begin
            if (fill_level >= heap_limit || fill_level >= MAX_ENTRIES) begin
               push_beat(zero, 0, STATUS_FULL, fill_level, 1'b1);
            end else begin
               fill_level++;
               heap_slots[fill_level].key = q.key;
               heap_slots[fill_level].tag = q.tag;
               post_slot(fill_level);
               c = sink(rise(fill_level));
               push_beat(heap_slots[c], c, STATUS_OK, fill_level, 1'b1);
            end
         end
         MODE_POP: begin
            if (fill_level == 0) begin
               push_beat(zero, 0, STATUS_EMPTY, 0, 1'b1);
            end else begin
               got = heap_slots[1];
               heap_slots[1] = heap_slots[fill_level];
               fill_level--;
               post_slot(1);
               c = sink(1);
               push_beat(got, 0, STATUS_OK, 0, 1'b0);
               push_beat(got, 0, STATUS_OK, fill_level, 1'b1);
            end
         end
         MODE_PEEK: begin
            if (fill_level == 0)
               push_beat(zero, 0, STATUS_EMPTY, 0, 1'b1);
            else
               push_beat(heap_slots[1], 1, STATUS_OK, fill_level, 1'b1);
         end
         MODE_REMOVE, MODE_REKEY: begin
            if (fill_level == 0) begin
               push_beat(zero, 0, STATUS_EMPTY, 0, 1'b1);
            end else if (p == 0 || p > fill_level) begin
               push_beat(zero, 0, STATUS_BADPOS, fill_level, 1'b1);
            end else if (q.mode == MODE_REMOVE) begin
               got = heap_slots[p];
               fill_level--;
               push_beat(got, 0, STATUS_OK, 0, 1'b0);
               if (p != fill_level + 1) begin
                  heap_slots[p] = heap_slots[fill_level + 1];
                  post_slot(p);
                  c = sink(rise(p));
               end
               push_beat(got, 0, STATUS_OK, fill_level, 1'b1);
            end else begin
               heap_slots[p].key = q.key;
               c = sink(rise(p));
               push_beat(heap_slots[c], c, STATUS_OK, fill_level, 1'b1);
            end
         end
         default: push_beat(zero, 0, STATUS_OK, fill_level, 1'b1);
      endcase
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         fill_level = 0;
         max_order  = 1'b0;
         heap_limit = 255;
         fail_count <= 0;
         expected_beats.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_ORDER)
               max_order = csr_data[0];
            else
               heap_limit = int'(csr_data);
         end
         if (req_valid && !req_stall)
            apply_op(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (expected_beats.size() == 0) begin
               $display("%0t: unexpected beat, expected none, got %p", $time, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_beats.pop_front();
               if (rsp_data !== want) begin
                  $display("%0t: beat mismatch, expected %p, got %p",
                           $time, want, rsp_data);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

// ===== sim/tb_indexed_binary_heap_queue.sv =====
// Testbench top for the indexed binary heap queue: drives operations and csr
// writes with random idling; ibhq_checker predicts and compares.
// Depends on ibhq_pkg, indexed_binary_heap_queue, ibhq_checker.
module tb_indexed_binary_heap_queue;
   import ibhq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic    csr_index = 1'b0;
   logic [7:0] csr_data = '0;
   int      fail_count;
   int      pending;
   int      cycle_count = 0;
   int      live_size = 0;
   int      cur_limit = 255;
   bit      quiet_tail = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   indexed_binary_heap_queue dut (.*);

   ibhq_checker checker_i (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // result side: random stall bursts, none during the quiet tail
   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 4);
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_op(logic [2:0] m, logic [31:0] k, logic [15:0] t, logic [7:0] p);
      if (!quiet_tail && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{mode: m, key: k, tag: t, position: p};
      do @(posedge clock); while (req_stall);
      // track size to steer the stimulus toward valid positions
      if (m == MODE_ADD && live_size < cur_limit) live_size++;
      else if ((m == MODE_POP || m == MODE_REMOVE) && live_size > 0 &&
               (m == MODE_POP || (p >= 1 && p <= live_size))) live_size--;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [7:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      if (idx == CSR_CAPACITY) cur_limit = int'(v);
   endtask

   task automatic rand_op();
      int r;
      logic [31:0] k;
      r = $urandom_range(0, 99);
      k = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 40);
      if (r < 40)
         send_op(MODE_ADD, k, 16'($urandom()), 8'($urandom()));
      else if (r < 55)
         send_op(MODE_POP, k, 16'($urandom()), 8'($urandom()));
      else if (r < 62)
         send_op(MODE_PEEK, k, 16'($urandom()), 8'($urandom()));
      else if (r < 76)
         send_op(MODE_REMOVE, k, 16'($urandom()),
                 (r < 74) ? 8'($urandom_range(1, live_size > 0 ? live_size : 1))
                          : 8'($urandom()));
      else if (r < 94)
         send_op(MODE_REKEY, k, 16'($urandom()),
                 (r < 92) ? 8'($urandom_range(1, live_size > 0 ? live_size : 1))
                          : 8'($urandom()));
      else
         send_op(3'($urandom_range(5, 7)), $urandom(), 16'($urandom()),
                 8'($urandom()));
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: errors on an empty heap, extremes, ties
      send_op(MODE_POP, '0, '0, '0);
      send_op(MODE_PEEK, '0, '0, '0);
      send_op(MODE_REMOVE, '0, '0, 8'd1);
      send_op(MODE_REKEY, '1, '0, 8'd1);
      send_op(3'd7, '1, '1, '1);
      send_op(MODE_ADD, 32'd7, 16'h0001, '0);
      send_op(MODE_POP, '0, '0, '0);
      send_op(MODE_ADD, '1, '1, '1);
      send_op(MODE_ADD, '0, 16'h00aa, '0);
      send_op(MODE_ADD, '0, 16'h00bb, '0);
      send_op(MODE_ADD, 32'd5, 16'h1234, '0);
      send_op(MODE_REMOVE, '0, '0, 8'd0);
      send_op(MODE_REKEY, '0, '0, 8'd255);
      send_op(MODE_REKEY, 32'hffff_fff0, '0, 8'd1);
      send_op(MODE_REMOVE, '0, '0, 8'd4);
      send_op(MODE_REMOVE, '0, '0, 8'd1);
      send_op(MODE_PEEK, '0, '0, '0);
      drain();

      // tiny capacity with max order: full case
      write_reg(CSR_ORDER, 8'd1);
      write_reg(CSR_CAPACITY, 8'd3);
      repeat (6) send_op(MODE_ADD, $urandom_range(0, 9), 16'($urandom()), '0);
      send_op(MODE_REKEY, '0, '0, 8'd1);
      repeat (40) rand_op();
      drain();

      write_reg(CSR_CAPACITY, 8'd0);
      send_op(MODE_ADD, 32'd1, 16'd1, '0);
      drain();

      write_reg(CSR_CAPACITY, 8'd1);
      repeat (20) rand_op();
      drain();

      write_reg(CSR_ORDER, 8'd0);
      write_reg(CSR_CAPACITY, 8'd255);
      repeat (60) rand_op();
      drain();

      // grow the heap several levels deep under max order
      write_reg(CSR_ORDER, 8'd1);
      while (live_size < 64) send_op(MODE_ADD, $urandom(), 16'($urandom()), '0);
      repeat (60) rand_op();
      drain();

      write_reg(CSR_CAPACITY, 8'd20);
      quiet_tail = 1'b1;
      repeat (60) rand_op();
      drain();

      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
